FILE: hdl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared field widths and codes of the power-of-two block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int ActionW    = 2;
  localparam int SizeW      = 24;
  localparam int BlockW     = 15;
  localparam int StatusW    = 3;
  localparam int LevelW     = 4;
  // payload bytes plus the block header
  localparam int NeedW      = SizeW + 1;
  localparam int HeaderBytes = 16;

  typedef logic [ActionW-1:0] action_t;

  localparam action_t ACT_ALLOC  = 2'd0;
  localparam action_t ACT_FREE   = 2'd1;
  localparam action_t ACT_RESIZE = 2'd2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_MOVE      = 3'd4
  } status_e;

endpackage

FILE: hdl/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/power_of_two_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_unit
// Buddy-style block allocator, one LIFO free list per level, no coalescing.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid_i/in_ready_o, action, size, block      | request
//  out     | out_valid_o/out_ready_i, status, block, level   | result
//
// allocate: S_WANT sizes the request, S_SEARCH walks the lists up from it, S_POP
//   pops a block, S_SPLIT splits it down and pushes each upper half, then S_RESP;
//   the sequencer and the single port of the link memory set this order.
// free and resize: S_LVL acts on the level memory read, then S_RESP gives the result.
// the next item is taken only in S_IDLE, once the last one has left S_RESP.
// reset empties every list but the top one; memories need no clearing.
// a finished result waits in the output register while the next item enters.
module power_of_two_block_allocator_unit #(
  parameter int NUM_LEVELS     = 16,
  parameter int MIN_BLOCK_LOG2 = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pba_pkg::ActionW-1:0] action_i,
  input  logic [pba_pkg::SizeW-1:0]   request_size_i,
  input  logic [pba_pkg::BlockW-1:0]  block_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pba_pkg::StatusW-1:0] status_o,
  output logic [pba_pkg::BlockW-1:0]  granted_block_o,
  output logic [pba_pkg::LevelW-1:0]  granted_level_o
);
  import pba_pkg::*;

  localparam int AddrW  = NUM_LEVELS - 1;
  localparam int Units  = 1 << AddrW;
  localparam int LvlW   = $clog2(NUM_LEVELS);
  localparam int LvlCW  = $clog2(NUM_LEVELS + 1);
  localparam int CmpW   = (NeedW > NUM_LEVELS + MIN_BLOCK_LOG2 + 1) ?
                          NeedW : NUM_LEVELS + MIN_BLOCK_LOG2 + 1;
  localparam int LinkW  = AddrW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WANT, S_SEARCH, S_POP, S_SPLIT, S_LVL, S_RESP
  } state_e;

  state_e              state_q, state_d;
  action_t             act_q, act_d;
  logic                zero_q, zero_d;
  logic [AddrW-1:0]    blk_q, blk_d;
  logic [CmpW-1:0]     need_q, need_d;
  logic [CmpW-1:0]     thr_q, thr_d;
  logic [LvlCW-1:0]    want_q, want_d;
  logic [LvlCW-1:0]    src_q, src_d;
  logic [AddrW-1:0]    got_q, got_d;
  logic                head_ok_q [NUM_LEVELS];
  logic                head_ok_d [NUM_LEVELS];
  logic [AddrW-1:0]    head_at_q [NUM_LEVELS];
  logic [AddrW-1:0]    head_at_d [NUM_LEVELS];
  logic                blk0_fresh_q, blk0_fresh_d;
  logic                out_valid_q, out_valid_d;
  status_e             res_st_q, res_st_d, out_st_q, out_st_d;
  logic [AddrW-1:0]    res_blk_q, res_blk_d, out_blk_q, out_blk_d;
  logic [LvlW-1:0]     res_lvl_q, res_lvl_d, out_lvl_q, out_lvl_d;

  // memory ports
  logic                link_we, lvl_we;
  logic [AddrW-1:0]    link_addr, lvl_addr;
  logic [LinkW-1:0]    link_wdata, link_rdata;
  logic [LvlW-1:0]     lvl_wdata, lvl_rdata;

  // list operations
  logic                pop_en, push_en;
  logic [LvlW-1:0]     push_lvl;
  logic [AddrW-1:0]    push_blk;

  logic [LvlW-1:0]     src_idx;
  logic [LvlCW-1:0]    src_dec;
  logic [LvlW-1:0]     cur_lvl;
  logic [CmpW-1:0]     have;

  function automatic logic [AddrW-1:0] ADDR_CAST(input logic [BlockW-1:0] b);
    return AddrW'(b);
  endfunction

  pba_ram #(.Width(LinkW), .Depth(Units)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  pba_ram #(.Width(LvlW), .Depth(Units)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .addr_i  (lvl_addr),
    .wdata_i (lvl_wdata),
    .rdata_o (lvl_rdata)
  );

  assign src_idx = src_q[LvlW-1:0];
  assign src_dec = src_q - 1'b1;
  // recorded level, clamped to the top level
  assign cur_lvl = (LvlCW'(lvl_rdata) >= LvlCW'(NUM_LEVELS)) ?
                   LvlW'(NUM_LEVELS - 1) : lvl_rdata;
  assign have    = CmpW'(1) << (cur_lvl + MIN_BLOCK_LOG2);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    zero_d      = zero_q;
    blk_d       = blk_q;
    need_d      = need_q;
    thr_d       = thr_q;
    want_d      = want_q;
    src_d       = src_q;
    got_d       = got_q;
    res_st_d    = res_st_q;
    res_blk_d   = res_blk_q;
    res_lvl_d   = res_lvl_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_blk_d   = out_blk_q;
    out_lvl_d   = out_lvl_q;
    pop_en      = 1'b0;
    push_en     = 1'b0;
    push_lvl    = '0;
    push_blk    = '0;
    link_addr   = head_at_q[src_idx];
    lvl_we      = 1'b0;
    lvl_addr    = ADDR_CAST(block_index_i);
    lvl_wdata   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_i;
          zero_d    = (request_size_i == '0);
          blk_d     = ADDR_CAST(block_index_i);
          need_d    = CmpW'(request_size_i) + CmpW'(HeaderBytes);
          thr_d     = CmpW'(1) << MIN_BLOCK_LOG2;
          want_d    = '0;
          res_st_d  = ST_OK;
          res_blk_d = '0;
          res_lvl_d = '0;
          unique case (action_i)
            ACT_ALLOC: begin
              if (request_size_i == '0) begin
                res_st_d = ST_ZERO;
                state_d  = S_RESP;
              end else begin
                state_d = S_WANT;
              end
            end
            ACT_FREE, ACT_RESIZE: state_d = S_LVL;
            default:              state_d = S_RESP;
          endcase
        end
      end

      S_WANT: begin
        if (want_q == LvlCW'(NUM_LEVELS)) begin
          res_st_d = ST_TOO_LARGE;
          state_d  = S_RESP;
        end else if (need_q > thr_q) begin
          want_d = want_q + 1'b1;
          thr_d  = thr_q << 1;
        end else begin
          src_d   = want_q;
          state_d = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (src_q == LvlCW'(NUM_LEVELS)) begin
          res_st_d = ST_NO_MEM;
          state_d  = S_RESP;
        end else if (head_ok_q[src_idx]) begin
          // link read issued here, data next cycle
          got_d   = head_at_q[src_idx];
          state_d = S_POP;
        end else begin
          src_d = src_q + 1'b1;
        end
      end

      S_POP: begin
        pop_en  = 1'b1;
        state_d = S_SPLIT;
      end

      S_SPLIT: begin
        if (src_q > want_q) begin
          src_d    = src_dec;
          push_en  = 1'b1;
          push_lvl = src_dec[LvlW-1:0];
          push_blk = got_q + (AddrW'(1) << src_dec);
        end else begin
          lvl_we    = 1'b1;
          lvl_addr  = got_q;
          lvl_wdata = want_q[LvlW-1:0];
          res_blk_d = got_q;
          res_lvl_d = want_q[LvlW-1:0];
          state_d   = S_RESP;
        end
      end

      S_LVL: begin
        lvl_addr  = blk_q;
        res_blk_d = blk_q;
        state_d   = S_RESP;
        if (act_q == ACT_FREE || zero_q) begin
          push_en   = 1'b1;
          push_lvl  = cur_lvl;
          push_blk  = blk_q;
          res_lvl_d = cur_lvl;
          res_st_d  = (act_q == ACT_RESIZE) ? ST_ZERO : ST_OK;
        end else if (cur_lvl != '0 && need_q < (have >> 1)) begin
          // shrink by one halving, upper half goes back on its list
          lvl_we    = 1'b1;
          lvl_wdata = cur_lvl - 1'b1;
          push_en   = 1'b1;
          push_lvl  = cur_lvl - 1'b1;
          push_blk  = blk_q + (AddrW'(1) << (cur_lvl - 1'b1));
          res_lvl_d = cur_lvl - 1'b1;
        end else begin
          res_lvl_d = cur_lvl;
          if (need_q > have) begin
            res_st_d = ST_MOVE;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_blk_d   = res_blk_q;
          out_lvl_d   = res_lvl_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (push_en) begin
      link_addr = push_blk;
    end
  end

  // pushes write the old head into the block's link
  assign link_we    = push_en;
  assign link_wdata = {head_ok_q[push_lvl], head_at_q[push_lvl]};

  always_comb begin
    head_ok_d    = head_ok_q;
    head_at_d    = head_at_q;
    blk0_fresh_d = blk0_fresh_q;
    if (pop_en) begin
      if (blk0_fresh_q && head_at_q[src_idx] == '0) begin
        // the block from reset has never had its link written
        head_ok_d[src_idx] = 1'b0;
        head_at_d[src_idx] = '0;
      end else begin
        head_ok_d[src_idx] = link_rdata[AddrW];
        head_at_d[src_idx] = link_rdata[AddrW-1:0];
      end
    end
    if (push_en) begin
      head_ok_d[push_lvl] = 1'b1;
      head_at_d[push_lvl] = push_blk;
      if (push_blk == '0) begin
        blk0_fresh_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      blk0_fresh_q <= 1'b1;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_ok_q[i] <= (i == NUM_LEVELS - 1);
        head_at_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      blk0_fresh_q <= blk0_fresh_d;
      head_ok_q    <= head_ok_d;
      head_at_q    <= head_at_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    zero_q    <= zero_d;
    blk_q     <= blk_d;
    need_q    <= need_d;
    thr_q     <= thr_d;
    want_q    <= want_d;
    src_q     <= src_d;
    got_q     <= got_d;
    res_st_q  <= res_st_d;
    res_blk_q <= res_blk_d;
    res_lvl_q <= res_lvl_d;
    out_st_q  <= out_st_d;
    out_blk_q <= out_blk_d;
    out_lvl_q <= out_lvl_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign granted_block_o = BlockW'(out_blk_q);
  assign granted_level_o = LevelW'(out_lvl_q);

endmodule
